### rtl/ptd_pkg.sv
// Shared types and constants for the periodic task dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package ptd_pkg;

  localparam int MAX_TASKS = 8;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_ENABLE  = 2'd2,
    CMD_DISABLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DUE  = 2'd0,
    ST_IDLE = 2'd1,
    ST_DONE = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  task_id;
    logic [15:0] period_ticks;
    logic [7:0]  priority_req;
    logic        start_enabled;
  } in_req_t;

  typedef struct packed {
    logic [7:0] task_id_res;
    status_t    status;
    logic       last;
  } out_res_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] period;
    logic [7:0]  prio;
    logic        enable;
    logic [31:0] last_run;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_FLUSH = 2'd2
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start_tick;
    logic do_add;
    logic do_enable;
    logic do_disable;
    logic scan_step;
    logic emit_final;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic blocked;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher: controller, datapath and checks.
// Add, enable and disable requests: one result, registered the cycle after acceptance.
// Tick requests: one table entry examined per cycle, except while a due entry waits on a
// stalled result register; the final result follows once every entry has been scanned.
// A new request is taken once the final result of the previous one is loaded.
// Reset clears the task count, tick counter and control; table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_dispatcher (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  ptd_pkg::in_req_t   in_req,
  output logic               out_valid,
  input  wire                out_stall,
  output ptd_pkg::out_res_t  out_res
);

  ptd_pkg::ctrl_t    ctl;
  ptd_pkg::dp_stat_t stat;

  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_req.cmd),
    .stat     (stat),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  ptd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_req    (in_req),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  a_step_final_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.scan_step && ctl.emit_final))
    else $error("scan step and final emit together");

  a_cmd_slot_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.do_add || ctl.do_enable || ctl.do_disable) |-> stat.out_free)
    else $error("request accepted with result register busy");

  a_final_marked: assert property (@(posedge clk) disable iff (rst)
    ctl.emit_final |=> (out_valid && out_res.last))
    else $error("final tick result not marked last");

  a_nonlast_due: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.last) |-> (out_res.status == ptd_pkg::ST_DUE))
    else $error("non-final result without due status");

endmodule
`default_nettype wire

### rtl/ptd_ctrl.sv
// Sequencing state machine for the task dispatcher.
`timescale 1ns / 1ps
`default_nettype none
module ptd_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  ptd_pkg::cmd_t     in_cmd,
  input  ptd_pkg::dp_stat_t stat,
  output logic              in_stall,
  output ptd_pkg::ctrl_t    ctl
);

  ptd_pkg::state_t state;
  ptd_pkg::state_t state_next;
  logic            accept;

  assign in_stall = !(state == ptd_pkg::S_IDLE && stat.out_free);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ptd_pkg::S_IDLE: begin
        if (accept && in_cmd == ptd_pkg::CMD_TICK) begin
          state_next = ptd_pkg::S_SCAN;
        end
      end
      ptd_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          state_next = ptd_pkg::S_FLUSH;
        end
      end
      ptd_pkg::S_FLUSH: begin
        if (stat.out_free) begin
          state_next = ptd_pkg::S_IDLE;
        end
      end
      default: state_next = ptd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ptd_pkg::S_IDLE: begin
        ctl.start_tick = accept && in_cmd == ptd_pkg::CMD_TICK;
        ctl.do_add     = accept && in_cmd == ptd_pkg::CMD_ADD;
        ctl.do_enable  = accept && in_cmd == ptd_pkg::CMD_ENABLE;
        ctl.do_disable = accept && in_cmd == ptd_pkg::CMD_DISABLE;
      end
      ptd_pkg::S_SCAN: begin
        ctl.scan_step = !stat.scan_done && (!stat.blocked || stat.out_free);
      end
      ptd_pkg::S_FLUSH: begin
        ctl.emit_final = stat.out_free;
      end
      default: ctl = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/ptd_datapath.sv
// Task table, tick counter, scan pointer and result register.
`timescale 1ns / 1ps
`default_nettype none
module ptd_datapath (
  input  wire                clk,
  input  wire                rst,
  input  ptd_pkg::in_req_t   in_req,
  input  ptd_pkg::ctrl_t     ctl,
  output ptd_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  wire                out_stall,
  output ptd_pkg::out_res_t  out_res
);

  ptd_pkg::entry_t                tbl      [ptd_pkg::MAX_TASKS];
  ptd_pkg::entry_t                tbl_next [ptd_pkg::MAX_TASKS];
  logic [ptd_pkg::CNT_W-1:0]      entry_count;
  logic [31:0]                    tick_counter;
  logic [ptd_pkg::CNT_W-1:0]      idx;
  logic                           pend;
  logic [7:0]                     pend_id;

  ptd_pkg::entry_t                cur;
  ptd_pkg::entry_t                new_entry;
  logic [31:0]                    elapsed;
  logic                           due;
  logic                           full;
  logic [ptd_pkg::CNT_W-1:0]      pos;
  logic                           res_load;
  ptd_pkg::out_res_t              res_next;

  assign cur     = tbl[idx[ptd_pkg::IDX_W-1:0]];
  assign elapsed = tick_counter - cur.last_run;
  assign due     = cur.enable && (cur.period == 16'd0 || elapsed >= 32'(cur.period));
  assign full    = entry_count >= ptd_pkg::CNT_W'(ptd_pkg::MAX_TASKS);

  assign stat.scan_done = idx >= entry_count;
  assign stat.blocked   = due && pend;
  assign stat.out_free  = !out_valid || !out_stall;

  assign new_entry = '{id:       in_req.task_id,
                       period:   in_req.period_ticks,
                       prio:     in_req.priority_req,
                       enable:   in_req.start_enabled,
                       last_run: 32'd0};

  // insertion point: entries with priority not above the new one stay ahead
  always_comb begin
    pos = '0;
    for (int i = 0; i < ptd_pkg::MAX_TASKS; i++) begin
      if (ptd_pkg::CNT_W'(i) < entry_count && tbl[i].prio <= in_req.priority_req) begin
        pos = pos + ptd_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ptd_pkg::MAX_TASKS; i++) begin
      tbl_next[i] = tbl[i];
    end
    if (ctl.do_add && !full) begin
      for (int j = 1; j < ptd_pkg::MAX_TASKS; j++) begin
        if (ptd_pkg::CNT_W'(j) > pos && ptd_pkg::CNT_W'(j) <= entry_count) begin
          tbl_next[j] = tbl[j-1];
        end
      end
      tbl_next[pos[ptd_pkg::IDX_W-1:0]] = new_entry;
    end
    if (ctl.do_enable || ctl.do_disable) begin
      for (int i = 0; i < ptd_pkg::MAX_TASKS; i++) begin
        if (tbl[i].id == in_req.task_id) begin
          tbl_next[i].enable = ctl.do_enable;
        end
      end
    end
    if (ctl.scan_step && due) begin
      tbl_next[idx[ptd_pkg::IDX_W-1:0]].last_run = tick_counter;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ptd_pkg::MAX_TASKS; i++) begin
      tbl[i] <= tbl_next[i];
    end
  end

  always_comb begin
    res_load = 1'b0;
    res_next = '{task_id_res: 8'd0, status: ptd_pkg::ST_DONE, last: 1'b1};
    if (ctl.do_add) begin
      res_load        = 1'b1;
      res_next.status = full ? ptd_pkg::ST_FULL : ptd_pkg::ST_DONE;
    end else if (ctl.do_enable || ctl.do_disable) begin
      res_load = 1'b1;
    end else if (ctl.scan_step && due && pend) begin
      res_load = 1'b1;
      res_next = '{task_id_res: pend_id, status: ptd_pkg::ST_DUE, last: 1'b0};
    end else if (ctl.emit_final) begin
      res_load = 1'b1;
      if (pend) begin
        res_next = '{task_id_res: pend_id, status: ptd_pkg::ST_DUE, last: 1'b1};
      end else begin
        res_next = '{task_id_res: 8'd0, status: ptd_pkg::ST_IDLE, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res_next;
    end
    if (ctl.scan_step && due) begin
      pend_id <= cur.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      tick_counter <= 32'd0;
      idx          <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (ctl.do_add && !full) begin
        entry_count <= entry_count + ptd_pkg::CNT_W'(1);
      end
      if (ctl.start_tick) begin
        tick_counter <= tick_counter + 32'd1;
        idx          <= '0;
        pend         <= 1'b0;
      end else if (ctl.scan_step) begin
        idx <= idx + ptd_pkg::CNT_W'(1);
        if (due) begin
          pend <= 1'b1;
        end
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
